/* sv/ledm_pkg.sv */
// Package for the scrolling LED matrix marquee.
// Item types, store sizing, reset values and command/register codes.
// No dependencies.
package ledm_pkg;

    localparam int MAX_GLYPHS  = 32;
    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_AW    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int GLYPH_BITS  = GLYPH_ROWS * 8;

    localparam logic [5:0]  COUNT_RESET    = 6'd14;
    localparam logic [15:0] INTERVAL_RESET = 16'd100;

    localparam logic CMD_TICK      = 1'b0;
    localparam logic CMD_ROW_WRITE = 1'b1;

    localparam logic REG_GLYPH_COUNT     = 1'b0;
    localparam logic REG_SCROLL_INTERVAL = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [4:0] glyph_slot;
        logic [2:0] glyph_row;
        logic [7:0] row_bits;
    } t_in_item;

    typedef struct packed {
        logic [2:0] scan_row;
        logic [7:0] column_select;
        logic [7:0] row_pattern;
        logic       last_row;
    } t_out_item;

endpackage

/* sv/led_matrix_scroll_marquee.sv */
// Scrolling 8x8 LED matrix marquee: glyph store, scroll timing and row scan output.
// Depends on ledm_pkg.
//
// Each input item is either a glyph row write or a one-millisecond tick. A row write
// never waits in the input register and produces no output. A tick produces eight scan
// words, rows 0..7, one per cycle unless i_stall holds them, from a single output
// register, after passing the input register and the read stage. The input side
// keeps taking items while scan words drain: one item waits in the input register
// and one tick waits after its glyph store read. The glyph store reads as blank after
// reset without a clearing pass, so items are taken right from reset.
module led_matrix_scroll_marquee (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  ledm_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output ledm_pkg::t_out_item  o_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = ledm_pkg::GLYPH_AW;
    localparam int GB = ledm_pkg::GLYPH_BITS;

    logic [GB-1:0] r_mem   [ledm_pkg::MAX_GLYPHS];
    logic [7:0]    r_valid [ledm_pkg::MAX_GLYPHS];

    logic [5:0]  r_count;
    logic [15:0] r_interval;
    logic [15:0] r_elapsed;
    logic [2:0]  r_shift;
    logic [5:0]  r_pos;
    logic [7:0]  r_display [ledm_pkg::GLYPH_ROWS];

    logic                r_s1_v;
    ledm_pkg::t_in_item  r_s1_item;

    logic          r_s2_v;
    logic          r_s2_scroll;
    logic [2:0]    r_s2_shift;
    logic          r_s2_blank_a;
    logic          r_s2_blank_b;
    logic [GB-1:0] r_s2_word_a;
    logic [GB-1:0] r_s2_word_b;
    logic [7:0]    r_s2_mask_a;
    logic [7:0]    r_s2_mask_b;

    logic       r_em_v;
    logic [2:0] r_em_idx;

    logic          out_take;
    logic          em_load;
    logic          s2_free;
    logic          s1_adv;
    logic          s1_tick;
    logic          s1_wr;
    logic          in_take;
    logic [6:0]    n_used;
    logic [15:0]   elapsed_inc;
    logic          do_scroll;
    logic [6:0]    frame_a;
    logic [6:0]    frame_b;
    logic [6:0]    frame_a_m1;
    logic          blank_a;
    logic          blank_b;
    logic [AW-1:0] idx_a;
    logic [AW-1:0] idx_b;
    logic [6:0]    slot_ext;
    logic          slot_ok;
    logic [AW-1:0] wr_idx;
    logic          cfg_wr;
    logic [7:0]    n_rows [ledm_pkg::GLYPH_ROWS];

    // handshake and pipeline advance
    assign out_take = r_em_v && !i_stall;
    assign em_load  = r_s2_v && (!r_em_v || (out_take && r_em_idx == 3'd7));
    assign s2_free  = !r_s2_v || em_load;
    assign s1_tick  = r_s1_v && (r_s1_item.cmd == ledm_pkg::CMD_TICK);
    assign s1_wr    = r_s1_v && (r_s1_item.cmd == ledm_pkg::CMD_ROW_WRITE);
    assign s1_adv   = s1_wr || (s1_tick && s2_free);
    assign o_stall  = r_s1_v && !s1_adv;
    assign in_take  = i_valid && !o_stall;

    // scroll timing and frame selection
    always_comb begin
        if ({1'b0, r_count} > 7'(ledm_pkg::MAX_GLYPHS)) begin
            n_used = 7'(ledm_pkg::MAX_GLYPHS);
        end else begin
            n_used = {1'b0, r_count};
        end
        elapsed_inc = r_elapsed + 16'd1;
        do_scroll   = (elapsed_inc >= r_interval);
        frame_a     = {1'b0, r_pos};
        frame_b     = frame_a + 7'd1;
        frame_a_m1  = frame_a - 7'd1;
        blank_a     = (frame_a == 7'd0) || (frame_a > n_used);
        blank_b     = (frame_b > n_used);
        idx_a       = frame_a_m1[AW-1:0];
        idx_b       = frame_a[AW-1:0];
        slot_ext    = {2'b00, r_s1_item.glyph_slot};
        slot_ok     = (slot_ext < 7'(ledm_pkg::MAX_GLYPHS));
        wr_idx      = slot_ext[AW-1:0];
    end

    // new display rows: low byte of {b, a} >> shift
    always_comb begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] pair;
        for (int r = 0; r < ledm_pkg::GLYPH_ROWS; r++) begin
            a = r_s2_blank_a ? 8'd0 :
                (r_s2_mask_a[r] ? r_s2_word_a[r*8 +: 8] : 8'd0);
            b = r_s2_blank_b ? 8'd0 :
                (r_s2_mask_b[r] ? r_s2_word_b[r*8 +: 8] : 8'd0);
            pair = {b, a} >> r_s2_shift;
            n_rows[r] = pair[7:0];
        end
    end

    // glyph store
    always_ff @(posedge i_clk) begin
        if (s1_wr && slot_ok) begin
            r_mem[wr_idx][{r_s1_item.glyph_row, 3'b000} +: 8] <= r_s1_item.row_bits;
        end
        if (s1_tick && s2_free) begin
            r_s2_word_a <= r_mem[idx_a];
            r_s2_word_b <= r_mem[idx_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < ledm_pkg::MAX_GLYPHS; g++) begin
                r_valid[g] <= 8'd0;
            end
        end else if (s1_wr && slot_ok) begin
            r_valid[wr_idx][r_s1_item.glyph_row] <= 1'b1;
        end
    end

    // configuration
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ledm_pkg::REG_GLYPH_COUNT) ? {26'd0, r_count}
                                                            : {16'd0, r_interval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= ledm_pkg::COUNT_RESET;
            r_interval <= ledm_pkg::INTERVAL_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == ledm_pkg::REG_GLYPH_COUNT) begin
                r_count <= pwdata[5:0];
            end else begin
                r_interval <= pwdata[15:0];
            end
        end
    end

    // input register and scroll state
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_elapsed <= 16'd0;
            r_shift   <= 3'd0;
            r_pos     <= 6'd0;
        end else begin
            if (in_take) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_tick && s2_free) begin
                if (do_scroll) begin
                    r_elapsed <= 16'd0;
                    r_shift   <= r_shift + 3'd1;
                    if (r_shift == 3'd7) begin
                        if (frame_a >= n_used) begin
                            r_pos <= 6'd0;
                        end else begin
                            r_pos <= r_pos + 6'd1;
                        end
                    end
                end else begin
                    r_elapsed <= elapsed_inc;
                end
            end
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (s1_tick && s2_free) begin
            r_s2_scroll  <= do_scroll;
            r_s2_shift   <= r_shift;
            r_s2_blank_a <= blank_a;
            r_s2_blank_b <= blank_b;
            r_s2_mask_a  <= r_valid[idx_a];
            r_s2_mask_b  <= r_valid[idx_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_tick && s2_free) begin
            r_s2_v <= 1'b1;
        end else if (em_load) begin
            r_s2_v <= 1'b0;
        end
    end

    // display rows and scan output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ledm_pkg::GLYPH_ROWS; r++) begin
                r_display[r] <= 8'd0;
            end
        end else if (em_load && r_s2_scroll) begin
            for (int r = 0; r < ledm_pkg::GLYPH_ROWS; r++) begin
                r_display[r] <= n_rows[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_v   <= 1'b0;
            r_em_idx <= 3'd0;
        end else if (em_load) begin
            r_em_v   <= 1'b1;
            r_em_idx <= 3'd0;
        end else if (out_take) begin
            r_em_idx <= r_em_idx + 3'd1;
            if (r_em_idx == 3'd7) begin
                r_em_v <= 1'b0;
            end
        end
    end

    assign o_valid              = r_em_v;
    assign o_item.scan_row      = r_em_idx;
    assign o_item.column_select = ~(8'd1 << r_em_idx);
    assign o_item.row_pattern   = r_display[r_em_idx];
    assign o_item.last_row      = (r_em_idx == 3'd7);

endmodule

/* sv/ledm_chk.sv */
// Port-level checks for the scrolling LED matrix marquee, bound to the top level.
// Depends on ledm_pkg and led_matrix_scroll_marquee.
module ledm_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input ledm_pkg::t_out_item o_item
);

    // scan words of one tick come back to back, rows in order
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_item.last_row
        |=> o_valid && (o_item.scan_row == $past(o_item.scan_row) + 3'd1))
        else $error("scan word sequence broken");

    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid) |-> o_item.scan_row == 3'd0)
        else $error("tick output does not start at row 0");

    a_col_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.column_select == ~(8'd1 << o_item.scan_row))
                    && (o_item.last_row == (o_item.scan_row == 3'd7)))
        else $error("column select or last row flag mismatch");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled scan word changed");

endmodule

bind led_matrix_scroll_marquee ledm_chk u_ledm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
